// ----- hdl/crt_pkg.sv -----
// ----------------------------------------------------------------------------
// crt_pkg: shared types and constants of the CORDIC twiddle rotator
// Word formats, quadrant fold codes, control bundle and arctangent table.
// ----------------------------------------------------------------------------
package crt_pkg;

  // angle accumulator width: folded angle up to 65408 plus table sum
  localparam int ANGLE_W = 19;
  localparam int ATAN_W  = 16;
  localparam int CFG_W   = 5;
  localparam logic [CFG_W-1:0] ITER_RESET = 5'd15;

  // arctangent of 2^-i in angle units
  localparam logic [ATAN_W-1:0] ATAN_TABLE [16] = '{
    16'd32768, 16'd19344, 16'd10221, 16'd5188, 16'd2604, 16'd1303,
    16'd652,   16'd326,   16'd163,   16'd81,   16'd41,   16'd20,
    16'd10,    16'd5,     16'd3,     16'd1
  };

  // quadrant fold applied up front, undone at the end
  typedef enum logic [1:0] {
    FOLD_NONE,
    FOLD_MIRROR,
    FOLD_QUARTER
  } fold_t;

  typedef struct packed {
    fold_t fold;
    logic  inv;
  } crt_ctl_t;

  typedef struct packed {
    logic signed [31:0] real_in;
    logic signed [31:0] imag_in;
    logic        [9:0]  twiddle_index;
    logic               mode;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] real_out;
    logic signed [31:0] imag_out;
  } out_word_t;

endpackage

// ----- hdl/crt_prescale.sv -----
// ----------------------------------------------------------------------------
// crt_prescale: quadrant fold and gain prescale stage
// Folds the twiddle index into the first quarter, swaps parts for the
// mirrored range, scales both parts by the shift-add gain and registers.
// ----------------------------------------------------------------------------
module crt_prescale #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  crt_pkg::in_word_t                   up_word,
  output logic                                dn_valid,
  input  logic                                dn_ready,
  output logic signed [DATA_WIDTH-1:0]        dn_re,
  output logic signed [DATA_WIDTH-1:0]        dn_im,
  output logic signed [crt_pkg::ANGLE_W-1:0]  dn_ang,
  output crt_pkg::crt_ctl_t                   dn_ctl
);

  localparam logic signed [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1);

  logic signed [DATA_WIDTH-1:0]       re_raw, im_raw, re_f, im_f;
  logic signed [DATA_WIDTH-1:0]       re_s1, re_s3, re_s6, re_s9;
  logic signed [DATA_WIDTH-1:0]       im_s1, im_s3, im_s6, im_s9;
  logic signed [DATA_WIDTH-1:0]       re_g, im_g;
  logic        [8:0]                  k_f;
  logic signed [crt_pkg::ANGLE_W-1:0] ang_f;
  crt_pkg::crt_ctl_t                  ctl_f;

  assign re_raw = up_word.real_in[DATA_WIDTH-1:0];
  assign im_raw = up_word.imag_in[DATA_WIDTH-1:0];

  // fold index into first quarter
  always_comb begin
    re_f     = re_raw;
    im_f     = im_raw;
    k_f      = up_word.twiddle_index[8:0];
    ctl_f.inv  = up_word.mode;
    ctl_f.fold = crt_pkg::FOLD_NONE;
    if (up_word.twiddle_index[9]) begin
      ctl_f.fold = crt_pkg::FOLD_QUARTER;
    end else if (up_word.twiddle_index[8]) begin
      k_f        = 9'(10'd512 - up_word.twiddle_index);
      ctl_f.fold = crt_pkg::FOLD_MIRROR;
      re_f       = im_raw;
      im_f       = re_raw;
    end
  end

  // angle = folded index * 128
  assign ang_f = crt_pkg::ANGLE_W'({k_f, 7'd0});

  // gain ~0.60725 = 1/2 + 1/8 - 1/64 - 1/512, with the -1 bias
  assign re_s1 = re_f >>> 1;
  assign re_s3 = re_f >>> 3;
  assign re_s6 = re_f >>> 6;
  assign re_s9 = re_f >>> 9;
  assign im_s1 = im_f >>> 1;
  assign im_s3 = im_f >>> 3;
  assign im_s6 = im_f >>> 6;
  assign im_s9 = im_f >>> 9;
  assign re_g  = re_s1 + re_s3 - re_s6 - re_s9 - ONE;
  assign im_g  = im_s1 + im_s3 - im_s6 - im_s9 - ONE;

  assign up_ready = !dn_valid || dn_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_re  <= re_g;
      dn_im  <= im_g;
      dn_ang <= ang_f;
      dn_ctl <= ctl_f;
    end
  end

endmodule

// ----- hdl/crt_cell.sv -----
// ----------------------------------------------------------------------------
// crt_cell: one CORDIC micro-rotation cell
// Rotates by +/- atan(2^-STAGE) toward zero residual angle, or passes the
// word through when the programmed iteration count does not reach it.
// ----------------------------------------------------------------------------
module crt_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int STAGE      = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [crt_pkg::CFG_W-1:0]           iter_count,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  logic signed [DATA_WIDTH-1:0]        up_re,
  input  logic signed [DATA_WIDTH-1:0]        up_im,
  input  logic signed [crt_pkg::ANGLE_W-1:0]  up_ang,
  input  crt_pkg::crt_ctl_t                   up_ctl,
  output logic                                dn_valid,
  input  logic                                dn_ready,
  output logic signed [DATA_WIDTH-1:0]        dn_re,
  output logic signed [DATA_WIDTH-1:0]        dn_im,
  output logic signed [crt_pkg::ANGLE_W-1:0]  dn_ang,
  output crt_pkg::crt_ctl_t                   dn_ctl
);

  localparam logic signed [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1);
  localparam logic signed [crt_pkg::ANGLE_W-1:0] STEP =
    crt_pkg::ANGLE_W'(crt_pkg::ATAN_TABLE[STAGE]);
  localparam logic [crt_pkg::CFG_W-1:0] STAGE_NUM = crt_pkg::CFG_W'(STAGE);

  logic                               active;
  logic signed [DATA_WIDTH-1:0]       im_sh, re_sh;
  logic signed [DATA_WIDTH-1:0]       re_n, im_n;
  logic signed [crt_pkg::ANGLE_W-1:0] ang_n;

  // cell takes part when the count reaches past it
  assign active = iter_count > STAGE_NUM;
  assign im_sh  = up_im >>> STAGE;
  assign re_sh  = up_re >>> STAGE;

  // micro-rotation, direction from residual angle sign
  always_comb begin
    re_n  = up_re;
    im_n  = up_im;
    ang_n = up_ang;
    if (active) begin
      if (!up_ang[crt_pkg::ANGLE_W-1]) begin
        ang_n = up_ang - STEP;
        if (up_ctl.inv) begin
          re_n = up_re - im_sh;
          im_n = up_im + re_sh - ONE;
        end else begin
          re_n = up_re + im_sh;
          im_n = up_im - re_sh - ONE;
        end
      end else begin
        ang_n = up_ang + STEP;
        if (up_ctl.inv) begin
          re_n = up_re + im_sh - ONE;
          im_n = up_im - re_sh;
        end else begin
          re_n = up_re - im_sh - ONE;
          im_n = up_im + re_sh;
        end
      end
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_re  <= re_n;
      dn_im  <= im_n;
      dn_ang <= ang_n;
      dn_ctl <= up_ctl;
    end
  end

endmodule

// ----- hdl/crt_fixup.sv -----
// ----------------------------------------------------------------------------
// crt_fixup: quadrant unfold and output register
// Undoes the input fold (quarter-turn swap or mirror negation), extends
// the parts to 32 bits and holds the result word for the output port.
// ----------------------------------------------------------------------------
module crt_fixup #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic signed [DATA_WIDTH-1:0]  up_re,
  input  logic signed [DATA_WIDTH-1:0]  up_im,
  input  crt_pkg::crt_ctl_t             up_ctl,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output crt_pkg::out_word_t            dn_word
);

  logic signed [DATA_WIDTH-1:0] re_n, im_n;

  // unfold quadrant; negation is the bitwise inverse
  always_comb begin
    re_n = up_re;
    im_n = up_im;
    case (up_ctl.fold)
      crt_pkg::FOLD_QUARTER: begin
        if (up_ctl.inv) begin
          re_n = ~up_im;
          im_n = up_re;
        end else begin
          re_n = up_im;
          im_n = ~up_re;
        end
      end
      crt_pkg::FOLD_MIRROR: begin
        if (up_ctl.inv) begin
          re_n = ~up_re;
        end else begin
          im_n = ~up_im;
        end
      end
      default: begin
        re_n = up_re;
        im_n = up_im;
      end
    endcase
  end

  assign up_ready = !dn_valid || dn_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_word.real_out <= 32'(re_n);
      dn_word.imag_out <= 32'(im_n);
    end
  end

endmodule

// ----- hdl/cordic_twiddle_rotator.sv -----
// ----------------------------------------------------------------------------
// cordic_twiddle_rotator: pipelined CORDIC twiddle rotator
// Rotates a complex sample by a twiddle angle for the FFT butterflies.
// ----------------------------------------------------------------------------
//   channel  signals                         word
//   -------  ------------------------------  ------------------------------
//   input    in_valid / in_stall (out)       in_word: real, imag, index, mode
//   output   out_valid / out_stall (in)      out_word: real, imag
//   config   cfg_wr_en / cfg_wr_data         iteration_count, 5 bits
//
// One word per cycle while out_stall is low. Words pass through a prescale
// stage, one cell per micro-rotation, and the unfold/output register.
// Cells past the programmed iteration count pass words through unchanged.
// Each stage has its own valid bit, so bubbles close up under out_stall
// and input keeps flowing until the whole chain is full.
// Synchronous reset empties the chain and sets iteration_count to 15.
// ----------------------------------------------------------------------------
module cordic_twiddle_rotator #(
  parameter int MAX_ITERATIONS = 16,
  parameter int DATA_WIDTH     = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [crt_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  crt_pkg::in_word_t             in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output crt_pkg::out_word_t            out_word
);

  logic [crt_pkg::CFG_W-1:0] iteration_count;

  // links between stages: index 0 is the prescale output
  logic                               lnk_valid [0:MAX_ITERATIONS];
  logic                               lnk_ready [0:MAX_ITERATIONS];
  logic signed [DATA_WIDTH-1:0]       lnk_re    [0:MAX_ITERATIONS];
  logic signed [DATA_WIDTH-1:0]       lnk_im    [0:MAX_ITERATIONS];
  logic signed [crt_pkg::ANGLE_W-1:0] lnk_ang   [0:MAX_ITERATIONS];
  crt_pkg::crt_ctl_t                  lnk_ctl   [0:MAX_ITERATIONS];
  logic                               in_ready;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_count <= crt_pkg::ITER_RESET;
    end else if (cfg_wr_en) begin
      iteration_count <= cfg_wr_data;
    end
  end

  assign in_stall = !in_ready;

  crt_prescale #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_prescale (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_word  (in_word),
    .dn_valid (lnk_valid[0]),
    .dn_ready (lnk_ready[0]),
    .dn_re    (lnk_re[0]),
    .dn_im    (lnk_im[0]),
    .dn_ang   (lnk_ang[0]),
    .dn_ctl   (lnk_ctl[0])
  );

  // micro-rotation chain
  for (genvar g = 0; g < MAX_ITERATIONS; g++) begin : g_cell
    crt_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .STAGE      (g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .iter_count (iteration_count),
      .up_valid   (lnk_valid[g]),
      .up_ready   (lnk_ready[g]),
      .up_re      (lnk_re[g]),
      .up_im      (lnk_im[g]),
      .up_ang     (lnk_ang[g]),
      .up_ctl     (lnk_ctl[g]),
      .dn_valid   (lnk_valid[g+1]),
      .dn_ready   (lnk_ready[g+1]),
      .dn_re      (lnk_re[g+1]),
      .dn_im      (lnk_im[g+1]),
      .dn_ang     (lnk_ang[g+1]),
      .dn_ctl     (lnk_ctl[g+1])
    );
  end

  crt_fixup #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_fixup (
    .clk      (clk),
    .rst      (rst),
    .up_valid (lnk_valid[MAX_ITERATIONS]),
    .up_ready (lnk_ready[MAX_ITERATIONS]),
    .up_re    (lnk_re[MAX_ITERATIONS]),
    .up_im    (lnk_im[MAX_ITERATIONS]),
    .up_ctl   (lnk_ctl[MAX_ITERATIONS]),
    .dn_valid (out_valid),
    .dn_ready (!out_stall),
    .dn_word  (out_word)
  );

endmodule

// ----- verif/cordic_twiddle_rotator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cordic_twiddle_rotator_tb: self-checking bench for the CORDIC twiddle rotator
// Drives sample words through the valid/stall channels and predicts each
// rotated word in the bench. The run covers quadrant folds, both modes,
// field extremes and several iteration counts, including zero and
// saturating values. Bursty input, patterned output stalls and a long
// output hold-off exercise back-pressure.
// ----------------------------------------------------------------------------
module cordic_twiddle_rotator_tb;

  localparam int ROT_STAGES     = 16;    // MAX_ITERATIONS of the block
  localparam int HOLD_CYCLES    = 60;    // long output hold-off, well past pipe depth
  localparam int QUIET_LIMIT    = 2000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES   = 40;    // wait after the drain for stray words
  localparam int PHASE_WORDS    = 80;
  localparam int DIR_ROWS       = 24;
  localparam logic MODE_FWD     = 1'b0;
  localparam logic MODE_INV     = 1'b1;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_style_t;

  typedef struct {
    logic [4:0]  iters;
    logic [31:0] re;
    logic [31:0] im;
    logic [9:0]  idx;
    logic        md;
    bit          typed;
    logic [31:0] exp_re;
    logic [31:0] exp_im;
  } dir_row_t;

  // directed words; expected values typed in only for the zero-iteration rows
  dir_row_t dir_table [DIR_ROWS] = '{
    '{5'd15, 32'h4000_0000, 32'h0000_0000, 10'd0,    MODE_FWD, 1'b0, 32'h0, 32'h0},
    '{5'd15, 32'h4000_0000, 32'h0000_0000, 10'd0,    MODE_INV, 1'b0, 32'h0, 32'h0},
    '{5'd15, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 10'd255,  MODE_FWD, 1'b0, 32'h0, 32'h0},
    '{5'd15, 32'h8000_0000, 32'h8000_0000, 10'd256,  MODE_INV, 1'b0, 32'h0, 32'h0},
    '{5'd15, 32'h1234_5678, 32'hEDCB_A987, 10'd257,  MODE_FWD, 1'b0, 32'h0, 32'h0},
    '{5'd15, 32'h7FFF_FFFF, 32'h8000_0000, 10'd511,  MODE_INV, 1'b0, 32'h0, 32'h0},
    '{5'd15, 32'h0001_0000, 32'hFFFF_0000, 10'd512,  MODE_FWD, 1'b0, 32'h0, 32'h0},
    '{5'd15, 32'h0001_0000, 32'hFFFF_0000, 10'd513,  MODE_INV, 1'b0, 32'h0, 32'h0},
    '{5'd15, 32'h5555_5555, 32'hAAAA_AAAA, 10'd767,  MODE_FWD, 1'b0, 32'h0, 32'h0},
    '{5'd15, 32'hAAAA_AAAA, 32'h5555_5555, 10'd768,  MODE_INV, 1'b0, 32'h0, 32'h0},
    '{5'd15, 32'hFFFF_FFFF, 32'h0000_0001, 10'd1023, MODE_FWD, 1'b0, 32'h0, 32'h0},
    '{5'd15, 32'h4000_0000, 32'h4000_0000, 10'd128,  MODE_INV, 1'b0, 32'h0, 32'h0},
    // zero iterations: prescale of zero gives -1, then the fold fix-up
    '{5'd0,  32'h0000_0000, 32'h0000_0000, 10'd0,    MODE_FWD, 1'b1,
      32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{5'd0,  32'h0000_0000, 32'h0000_0000, 10'd512,  MODE_FWD, 1'b1,
      32'hFFFF_FFFF, 32'h0000_0000},
    '{5'd0,  32'h0000_0000, 32'h0000_0000, 10'd512,  MODE_INV, 1'b1,
      32'h0000_0000, 32'hFFFF_FFFF},
    '{5'd0,  32'h0000_0000, 32'h0000_0000, 10'd256,  MODE_FWD, 1'b1,
      32'hFFFF_FFFF, 32'h0000_0000},
    '{5'd0,  32'h0000_0000, 32'h0000_0000, 10'd256,  MODE_INV, 1'b1,
      32'h0000_0000, 32'hFFFF_FFFF},
    '{5'd0,  32'h8000_0000, 32'h7FFF_FFFF, 10'd0,    MODE_FWD, 1'b1,
      32'hB23F_FFFF, 32'h4DBF_FFFF},
    // full table, then a count that saturates, then a single iteration
    '{5'd16, 32'h7FFF_FFFF, 32'h0000_0000, 10'd1023, MODE_INV, 1'b0, 32'h0, 32'h0},
    '{5'd16, 32'h8000_0000, 32'h7FFF_FFFF, 10'd384,  MODE_FWD, 1'b0, 32'h0, 32'h0},
    '{5'd31, 32'h4000_0000, 32'h4000_0000, 10'd700,  MODE_FWD, 1'b0, 32'h0, 32'h0},
    '{5'd31, 32'h8000_0000, 32'h8000_0000, 10'd0,    MODE_INV, 1'b0, 32'h0, 32'h0},
    '{5'd1,  32'h7FFF_FFFF, 32'h8000_0000, 10'd300,  MODE_FWD, 1'b0, 32'h0, 32'h0},
    '{5'd1,  32'h0000_0003, 32'hFFFF_FFFD, 10'd600,  MODE_INV, 1'b0, 32'h0, 32'h0}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [4:0]          cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  crt_pkg::in_word_t   in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  crt_pkg::out_word_t  out_word;

  // bench state
  crt_pkg::out_word_t pending_rotations [$];
  logic [4:0]         iter_shadow = crt_pkg::ITER_RESET;
  logic [4:0]         cur_iters = crt_pkg::ITER_RESET;
  bit                 use_typed = 1'b0;
  crt_pkg::out_word_t typed_result = '0;
  int                 mismatch_count = 0;
  int                 burst_left = 0;
  int                 gap_max = 0;
  stall_style_t       stall_style = STALL_NONE;
  bit                 hold_req = 1'b0;
  int                 hold_left = 0;
  int unsigned        stall_tick = 0;

  cordic_twiddle_rotator dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shift-add approximation of the CORDIC gain, with its -1 bias
  function automatic logic signed [31:0] gain_prescale(input logic signed [31:0] a);
    return (a >>> 1) + (a >>> 3) - (a >>> 6) - (a >>> 9) - 32'sd1;
  endfunction

  // expected rotated word for one sample at a given iteration count
  function automatic crt_pkg::out_word_t rotate_twiddle(input crt_pkg::in_word_t w,
                                                        input logic [4:0] iters);
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] xp;
    logic signed [31:0] t;
    int                 ang;
    int                 steps;
    crt_pkg::fold_t     fq;
    crt_pkg::out_word_t r;
    x   = w.real_in;
    y   = w.imag_in;
    ang = int'(w.twiddle_index);
    fq  = crt_pkg::FOLD_NONE;
    // fold the angle into the first quarter
    if (ang >= 512) begin
      ang = ang - 512;
      fq  = crt_pkg::FOLD_QUARTER;
    end else if (ang >= 256) begin
      ang = 512 - ang;
      fq  = crt_pkg::FOLD_MIRROR;
      t = x; x = y; y = t;
    end
    x     = gain_prescale(x);
    y     = gain_prescale(y);
    ang   = ang * 128;
    steps = (int'(iters) > ROT_STAGES) ? ROT_STAGES : int'(iters);
    // micro-rotations toward zero residual angle
    for (int i = 0; i < steps; i++) begin
      xp = x;
      if (ang >= 0) begin
        ang = ang - int'(crt_pkg::ATAN_TABLE[i]);
        if (w.mode == MODE_INV) begin
          x = x - (y >>> i);
          y = y + (xp >>> i) - 32'sd1;
        end else begin
          x = x + (y >>> i);
          y = y - (xp >>> i) - 32'sd1;
        end
      end else begin
        ang = ang + int'(crt_pkg::ATAN_TABLE[i]);
        if (w.mode == MODE_INV) begin
          x = x + (y >>> i) - 32'sd1;
          y = y - (xp >>> i);
        end else begin
          x = x - (y >>> i) - 32'sd1;
          y = y + (xp >>> i);
        end
      end
    end
    // undo the fold
    case (fq)
      crt_pkg::FOLD_QUARTER: begin
        if (w.mode == MODE_INV) begin
          t = y; y = x; x = ~t;
        end else begin
          t = x; x = y; y = ~t;
        end
      end
      crt_pkg::FOLD_MIRROR: begin
        if (w.mode == MODE_INV) x = ~x;
        else y = ~y;
      end
      default: ;
    endcase
    r.real_out = x;
    r.imag_out = y;
    return r;
  endfunction

  // sample and check at the rising edge
  always @(posedge clk) begin
    crt_pkg::out_word_t want;
    if (rst) begin
      iter_shadow = crt_pkg::ITER_RESET;
    end else begin
      if (in_valid && !in_stall) begin
        pending_rotations.push_back(use_typed ? typed_result
                                              : rotate_twiddle(in_word, iter_shadow));
      end
      if (out_valid && !out_stall) begin
        if (pending_rotations.size() == 0) begin
          $display("%0t: unexpected word real_out %h imag_out %h", $time,
                   out_word.real_out, out_word.imag_out);
          mismatch_count++;
        end else begin
          want = pending_rotations.pop_front();
          if (out_word.real_out !== want.real_out) begin
            $display("%0t: real_out mismatch expected %h actual %h", $time,
                     want.real_out, out_word.real_out);
            mismatch_count++;
          end
          if (out_word.imag_out !== want.imag_out) begin
            $display("%0t: imag_out mismatch expected %h actual %h", $time,
                     want.imag_out, out_word.imag_out);
            mismatch_count++;
          end
        end
      end
      if (cfg_wr_en) iter_shadow = cfg_wr_data;
    end
  end

  // receiver stall: long hold-off on request, else the phase's pattern
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall = 1'b1;
    end else begin
      case (stall_style)
        STALL_RANDOM:   out_stall = ($urandom_range(0, 99) < 35);
        STALL_PERIODIC: out_stall = ((stall_tick % 7) < 3);
        default:        out_stall = 1'b0;
      endcase
    end
    stall_tick++;
  end

  // watchdog on cycles with no handshake
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL");
    $finish;
  end

  // offer one word in bursts; returns at the falling edge after acceptance
  task automatic drive_word(input crt_pkg::in_word_t w, input bit typed,
                            input crt_pkg::out_word_t exp_w);
    int  gap;
    bit  took;
    if (burst_left <= 0) begin
      gap = (gap_max > 0) ? $urandom_range(1, gap_max) : 0;
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_word      = w;
    use_typed    = typed;
    typed_result = exp_w;
    in_valid     = 1'b1;
    took         = 1'b0;
    while (!took) begin
      @(posedge clk);
      took = !in_stall;
      @(negedge clk);
    end
    burst_left--;
  endtask

  // write the iteration count once the pipe has drained
  task automatic set_iterations(input logic [4:0] v);
    in_valid = 1'b0;
    while (pending_rotations.size() != 0) @(negedge clk);
    cfg_wr_data = v;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    cur_iters   = v;
  endtask

  function automatic logic [31:0] pick_part();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'($signed($urandom_range(0, 4000)) - 2000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [9:0] pick_index();
    logic [9:0] edges [10] = '{10'd0, 10'd255, 10'd256, 10'd257, 10'd511,
                                10'd512, 10'd513, 10'd767, 10'd768, 10'd1023};
    if ($urandom_range(0, 4) == 0) return edges[$urandom_range(0, 9)];
    return 10'($urandom_range(0, 1023));
  endfunction

  initial begin
    crt_pkg::in_word_t  w;
    crt_pkg::out_word_t e;
    logic [4:0] phase_iters [7] = '{5'd15, 5'd0, 5'd16, 5'd31, 5'd1, 5'd0, 5'd0};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    gap_max     = 3;
    stall_style = STALL_RANDOM;
    foreach (dir_table[r]) begin
      if (dir_table[r].iters != cur_iters) set_iterations(dir_table[r].iters);
      w.real_in       = dir_table[r].re;
      w.imag_in       = dir_table[r].im;
      w.twiddle_index = dir_table[r].idx;
      w.mode          = dir_table[r].md;
      e.real_out      = dir_table[r].exp_re;
      e.imag_out      = dir_table[r].exp_im;
      drive_word(w, dir_table[r].typed, e);
    end

    // random phases, one iteration count each
    phase_iters[5] = 5'($urandom_range(0, 31));
    phase_iters[6] = 5'($urandom_range(2, 14));
    for (int p = 0; p < 7; p++) begin
      set_iterations(phase_iters[p]);
      stall_style = stall_style_t'(p % 3);
      gap_max     = (p % 3 == 0) ? 0 : $urandom_range(2, 8);
      // first phase: receiver holds off while words keep coming
      if (p == 0) hold_req = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        w.real_in       = pick_part();
        w.imag_in       = pick_part();
        w.twiddle_index = pick_index();
        w.mode          = 1'($urandom_range(0, 1));
        drive_word(w, 1'b0, '0);
      end
    end

    // drain, then allow for stray words
    in_valid = 1'b0;
    while (pending_rotations.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_rotations.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
